@@ rtl/bir_pkg.sv @@
package bir_pkg;

    localparam int CFG_W   = 10;
    localparam int COORD_W = 9;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int NUM_TAP = 4;
    localparam int PIX_W   = NUM_CH * CH_W;
    localparam int DENW    = CFG_W + 1;
    localparam int IDX_W   = 2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [IDX_W-1:0] REG_SRC_W = 2'd0;
    localparam logic [IDX_W-1:0] REG_SRC_H = 2'd1;
    localparam logic [IDX_W-1:0] REG_TGT_W = 2'd2;
    localparam logic [IDX_W-1:0] REG_TGT_H = 2'd3;

endpackage

@@ rtl/bir_ram.sv @@
module bir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/bir_div.sv @@
module bir_div #(
    parameter int NUMW  = 20,
    parameter int INTW  = 9,
    parameter int FRACW = 16
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [NUMW-1:0]         num,
    input  logic [bir_pkg::DENW-1:0] den,
    output logic [INTW+FRACW-1:0]   quo
);
    import bir_pkg::*;

    localparam int QB = INTW + FRACW;

    logic [DENW-1:0] rem_reg  [QB-1];
    logic [QB-1:0]   work_reg [QB];
    logic [DENW-1:0] rem_src  [QB];
    logic [QB-1:0]   work_src [QB];
    logic [DENW-1:0] rem_nx   [QB];
    logic [QB-1:0]   work_nx  [QB];
    logic [DENW:0]   trial    [QB];

    // one quotient bit per stage, restoring form
    always_comb
    begin
        rem_src[0]  = DENW'(num >> INTW);
        work_src[0] = {num[INTW-1:0], {FRACW{1'b0}}};
        for (int i = 1; i < QB; i++)
        begin
            rem_src[i]  = rem_reg[i-1];
            work_src[i] = work_reg[i-1];
        end
        for (int i = 0; i < QB; i++)
        begin
            trial[i] = {rem_src[i], work_src[i][QB-1]};
            if (trial[i] >= {1'b0, den})
            begin
                rem_nx[i]  = DENW'(trial[i] - {1'b0, den});
                work_nx[i] = {work_src[i][QB-2:0], 1'b1};
            end
            else
            begin
                rem_nx[i]  = trial[i][DENW-1:0];
                work_nx[i] = {work_src[i][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QB - 1; i++)
            begin
                rem_reg[i] <= rem_nx[i];
            end
            for (int i = 0; i < QB; i++)
            begin
                work_reg[i] <= work_nx[i];
            end
        end
    end

    assign quo = work_reg[QB-1];

endmodule

@@ rtl/bir_lane.sv @@
module bir_lane #(
    parameter int WB = 16
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [bir_pkg::NUM_TAP-1:0][bir_pkg::CH_W-1:0] px,
    input  logic [bir_pkg::NUM_TAP-1:0][2*WB:0]    kw,
    output logic [bir_pkg::CH_W-1:0]               pix
);
    import bir_pkg::*;

    localparam int AW = 2 * WB + CH_W;

    logic [AW-1:0] prod_reg [NUM_TAP];
    logic [AW-1:0] acc;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NUM_TAP; j++)
            begin
                prod_reg[j] <= AW'(px[j]) * AW'(kw[j]);
            end
        end
    end

    // four-tap sum, round half up
    always_comb
    begin
        acc = AW'(1) << (2 * WB - 1);
        for (int j = 0; j < NUM_TAP; j++)
        begin
            acc = acc + prod_reg[j];
        end
    end

    assign pix = acc[AW-1:2*WB];

endmodule

@@ rtl/bilinear_image_resize.sv @@
// bilinear image resize, three 8-bit channels, half-pixel centers
// config: pulse cfg_write with cfg_index (0 src width, 1 src height,
//   2 target width, 3 target height) and cfg_data; only while idle
// input words (in_valid/in_ready): action 0 stores a source pixel at
//   (col,row); action 1 requests target pixel (col,row)
// output words (out_valid/out_ready): one per request, in order; writes
//   give none. out_of_range flags a request outside the target size,
//   channels are then zero
// throughput: one word per cycle while no result waits on out_ready; four
//   frame store copies give the four neighbor reads in the same cycle
// the whole pipeline stalls while a result waits on out_ready; in_ready
//   then drops
// reset: config returns to 512 for all sizes, pipeline empties; the frame
//   store is not cleared and must be written before it is read
module bilinear_image_resize #(
    parameter int MAX_WIDTH   = 512,
    parameter int MAX_HEIGHT  = 512,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bir_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bir_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [bir_pkg::COORD_W-1:0]   col,
    input  logic [bir_pkg::COORD_W-1:0]   row,
    input  logic [bir_pkg::CH_W-1:0]      blue_in,
    input  logic [bir_pkg::CH_W-1:0]      green_in,
    input  logic [bir_pkg::CH_W-1:0]      red_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bir_pkg::CH_W-1:0]      blue_out,
    output logic [bir_pkg::CH_W-1:0]      green_out,
    output logic [bir_pkg::CH_W-1:0]      red_out,
    output logic                          out_of_range
);
    import bir_pkg::*;

    localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int IDXW = $clog2(MAXD);
    localparam int SRCW = $clog2(MAXD + 1);
    localparam int XB   = $clog2(MAX_WIDTH);
    localparam int YB   = $clog2(MAX_HEIGHT);
    localparam int AB   = XB + YB;
    localparam int WB   = WEIGHT_BITS;
    localparam int QB   = IDXW + WB;
    localparam int NUMW = CFG_W + SRCW;
    localparam int KW   = 2 * WB + 1;

    typedef struct packed {
        logic              rd;
        logic              oor;
        logic              wr_ok;
        logic [XB-1:0]     x;
        logic [YB-1:0]     y;
        logic [PIX_W-1:0]  data;
    } side_t;

    logic [CFG_W-1:0] sw_reg, sh_reg, tw_reg, th_reg;
    logic [SRCW-1:0]  srcx, srcy;
    logic             en;

    logic [NUMW-1:0]  prod_x, prod_y, num_x, num_y;
    logic             oor_in;
    side_t            s0_next;
    logic             s0_valid_reg;
    side_t            s0_sb_reg;
    logic [NUMW-1:0]  numx_reg, numy_reg;

    logic             sb_valid_reg [QB];
    side_t            sb_reg [QB];
    logic [QB-1:0]    quo_x, quo_y;

    logic [IDXW-1:0]  fx, fy, x1, y1;
    logic [IDXW:0]    fx_inc, fy_inc;
    side_t            sb_last;

    logic             a_valid_reg, a_rd_reg, a_oor_reg, a_wr_reg;
    logic [XB-1:0]    a_x0_reg, a_x1_reg;
    logic [YB-1:0]    a_y0_reg, a_y1_reg;
    logic [WB-1:0]    a_wx_reg, a_wy_reg;
    logic [PIX_W-1:0] a_data_reg;
    logic [WB:0]      owx, owy;
    logic [NUM_TAP-1:0][KW-1:0] k_next;

    logic             b_valid_reg, b_rd_reg, b_oor_reg;
    logic [NUM_TAP-1:0][KW-1:0]  b_k_reg;
    logic [NUM_TAP-1:0][AB-1:0]  ram_raddr;
    logic [NUM_TAP-1:0][PIX_W-1:0] ram_rd;
    logic             ram_we;

    logic [NUM_CH-1:0][NUM_TAP-1:0][CH_W-1:0] lane_px;
    logic [NUM_CH-1:0][CH_W-1:0] lane_pix;

    logic             c_valid_reg, c_rd_reg, c_oor_reg;
    logic             out_valid_reg;
    logic [CH_W-1:0]  blue_reg, green_reg, red_reg;
    logic             oor_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= CFG_W'(512);
            sh_reg <= CFG_W'(512);
            tw_reg <= CFG_W'(512);
            th_reg <= CFG_W'(512);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SRC_W: sw_reg <= cfg_data;
                REG_SRC_H: sh_reg <= cfg_data;
                REG_TGT_W: tw_reg <= cfg_data;
                REG_TGT_H: th_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        if (sw_reg == '0)
            srcx = SRCW'(1);
        else if (int'(sw_reg) > MAX_WIDTH)
            srcx = SRCW'(MAX_WIDTH);
        else
            srcx = SRCW'(sw_reg);
        if (sh_reg == '0)
            srcy = SRCW'(1);
        else if (int'(sh_reg) > MAX_HEIGHT)
            srcy = SRCW'(MAX_HEIGHT);
        else
            srcy = SRCW'(sh_reg);
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // entry stage: numerator (2t+1)*src - tgt; a negative one has floor -1,
    // so one denominator is added back and the fraction stays exact
    always_comb
    begin
        prod_x = NUMW'({col, 1'b1}) * NUMW'(srcx);
        prod_y = NUMW'({row, 1'b1}) * NUMW'(srcy);
        oor_in = ({1'b0, col} >= tw_reg) || ({1'b0, row} >= th_reg);
        if (oor_in)
            num_x = '0;
        else if (prod_x >= NUMW'(tw_reg))
            num_x = prod_x - NUMW'(tw_reg);
        else
            num_x = prod_x + NUMW'(tw_reg);
        if (oor_in)
            num_y = '0;
        else if (prod_y >= NUMW'(th_reg))
            num_y = prod_y - NUMW'(th_reg);
        else
            num_y = prod_y + NUMW'(th_reg);
        s0_next.rd    = (action == ACT_READ);
        s0_next.oor   = oor_in;
        s0_next.wr_ok = (int'(col) < MAX_WIDTH) && (int'(row) < MAX_HEIGHT);
        s0_next.x     = XB'(col);
        s0_next.y     = YB'(row);
        s0_next.data  = {red_in, green_in, blue_in};
    end

    bir_div #(.NUMW(NUMW), .INTW(IDXW), .FRACW(WB)) u_div_x (
        .clk (clk),
        .en  (en),
        .num (numx_reg),
        .den ({tw_reg, 1'b0}),
        .quo (quo_x)
    );

    bir_div #(.NUMW(NUMW), .INTW(IDXW), .FRACW(WB)) u_div_y (
        .clk (clk),
        .en  (en),
        .num (numy_reg),
        .den ({th_reg, 1'b0}),
        .quo (quo_y)
    );

    // neighbor indexes
    always_comb
    begin
        sb_last = sb_reg[QB-1];
        fx      = quo_x[QB-1:WB];
        fy      = quo_y[QB-1:WB];
        fx_inc  = {1'b0, fx} + 1'b1;
        fy_inc  = {1'b0, fy} + 1'b1;
        x1      = (fx_inc >= (IDXW+1)'(srcx)) ? fx : fx_inc[IDXW-1:0];
        y1      = (fy_inc >= (IDXW+1)'(srcy)) ? fy : fy_inc[IDXW-1:0];
    end

    // tap weights
    always_comb
    begin
        owx       = {1'b1, {WB{1'b0}}} - {1'b0, a_wx_reg};
        owy       = {1'b1, {WB{1'b0}}} - {1'b0, a_wy_reg};
        k_next[0] = KW'(owx) * KW'(owy);
        k_next[1] = KW'(a_wx_reg) * KW'(owy);
        k_next[2] = KW'(owx) * KW'(a_wy_reg);
        k_next[3] = KW'(a_wx_reg) * KW'(a_wy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            for (int i = 0; i < QB; i++)
            begin
                sb_valid_reg[i] <= 1'b0;
            end
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg    <= in_valid;
            sb_valid_reg[0] <= s0_valid_reg;
            for (int i = 1; i < QB; i++)
            begin
                sb_valid_reg[i] <= sb_valid_reg[i-1];
            end
            a_valid_reg   <= sb_valid_reg[QB-1];
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg && c_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_sb_reg <= s0_next;
            numx_reg  <= num_x;
            numy_reg  <= num_y;
            sb_reg[0] <= s0_sb_reg;
            for (int i = 1; i < QB; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
            a_rd_reg   <= sb_last.rd;
            a_oor_reg  <= sb_last.oor;
            a_wr_reg   <= !sb_last.rd && sb_last.wr_ok;
            a_x0_reg   <= sb_last.rd ? XB'(fx) : sb_last.x;
            a_x1_reg   <= sb_last.rd ? XB'(x1) : sb_last.x;
            a_y0_reg   <= sb_last.rd ? YB'(fy) : sb_last.y;
            a_y1_reg   <= sb_last.rd ? YB'(y1) : sb_last.y;
            a_wx_reg   <= quo_x[WB-1:0];
            a_wy_reg   <= quo_y[WB-1:0];
            a_data_reg <= sb_last.data;
            b_rd_reg   <= a_rd_reg;
            b_oor_reg  <= a_oor_reg;
            b_k_reg    <= k_next;
            c_rd_reg   <= b_rd_reg;
            c_oor_reg  <= b_oor_reg;
            oor_reg    <= c_oor_reg;
            blue_reg   <= c_oor_reg ? '0 : lane_pix[0];
            green_reg  <= c_oor_reg ? '0 : lane_pix[1];
            red_reg    <= c_oor_reg ? '0 : lane_pix[2];
        end
    end

    // frame store copies, one per tap
    assign ram_we       = en && a_valid_reg && a_wr_reg;
    assign ram_raddr[0] = {a_y0_reg, a_x0_reg};
    assign ram_raddr[1] = {a_y0_reg, a_x1_reg};
    assign ram_raddr[2] = {a_y1_reg, a_x0_reg};
    assign ram_raddr[3] = {a_y1_reg, a_x1_reg};

    for (genvar j = 0; j < NUM_TAP; j++)
    begin : g_tap
        bir_ram #(.WIDTH(PIX_W), .DEPTH(1 << AB)) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr ({a_y0_reg, a_x0_reg}),
            .wdata (a_data_reg),
            .re    (en),
            .raddr (ram_raddr[j]),
            .rdata (ram_rd[j])
        );
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            for (int j = 0; j < NUM_TAP; j++)
            begin
                lane_px[c][j] = ram_rd[j][CH_W*c +: CH_W];
            end
        end
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        bir_lane #(.WB(WB)) u_lane (
            .clk (clk),
            .en  (en),
            .px  (lane_px[c]),
            .kw  (b_k_reg),
            .pix (lane_pix[c])
        );
    end

    assign out_valid    = out_valid_reg;
    assign blue_out     = blue_reg;
    assign green_out    = green_reg;
    assign red_out      = red_reg;
    assign out_of_range = oor_reg;

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && oor_reg |-> blue_reg == '0 && green_reg == '0 && red_reg == '0)
        else $error("out of range word carries nonzero channels");

    a_tap_order: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && a_rd_reg && !a_oor_reg |-> a_x0_reg <= a_x1_reg && a_y0_reg <= a_y1_reg)
        else $error("second neighbor before first neighbor");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(c_valid_reg && c_rd_reg))
        else $error("result word without a request");

endmodule
